// ----- rtl/core/lfrs_pkg.sv -----
package lfrs_pkg;

    // Widths of the external fields.
    localparam int STAMP_W = 32;
    localparam int TIME_W  = 48;
    localparam int COUNT_W = 32;
    localparam int ROOM_W  = 4;
    localparam int CFG_W   = 5;

    // Default number of room entries and the reset value of the room-count register.
    localparam int ROOMS_DEF = 16;
    localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(16);

    // Saturation limits.
    localparam logic [TIME_W-1:0]  TIME_MAX  = '1;
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    // One word of the room table.
    typedef struct packed {
        logic [TIME_W-1:0]  free_at;
        logic [COUNT_W-1:0] use_count;
    } t_room_rec;

    // Sequencer states of the top level.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_CALC,
        ST_DONE
    } t_state;

endpackage

// ----- rtl/core/lfrs_room_mem.sv -----
module lfrs_room_mem #(
    parameter  int ROOMS = lfrs_pkg::ROOMS_DEF,
    localparam int IDX_W = (ROOMS > 1) ? $clog2(ROOMS) : 1
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [IDX_W-1:0]              i_rd_addr,
    output lfrs_pkg::t_room_rec           o_rd_data,
    input  logic                          i_wr_en,
    input  logic [IDX_W-1:0]              i_wr_addr,
    input  lfrs_pkg::t_room_rec           i_wr_data
);

    lfrs_pkg::t_room_rec r_mem [ROOMS];
    logic [ROOMS-1:0]    r_valid;
    lfrs_pkg::t_room_rec r_rd_data;
    logic                r_rd_ok;

    // Valid bits stand in for the all-zero reset of the table.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_rd_ok <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_valid[i_wr_addr] <= 1'b1;
            end
            r_rd_ok <= r_valid[i_rd_addr];
        end
    end

    // Storage array with one write and one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    // An entry never written reads as zero.
    assign o_rd_data = r_rd_ok ? r_rd_data : '0;

endmodule

// ----- rtl/core/lfrs_scan.sv -----
module lfrs_scan #(
    parameter  int ROOMS = lfrs_pkg::ROOMS_DEF,
    localparam int IDX_W = (ROOMS > 1) ? $clog2(ROOMS) : 1,
    localparam int NUM_W = $clog2(ROOMS + 1)
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [NUM_W-1:0]              i_n,
    input  logic [lfrs_pkg::STAMP_W-1:0]  i_start_time,
    output logic [IDX_W-1:0]              o_rd_addr,
    input  lfrs_pkg::t_room_rec           i_rd_data,
    output logic                          o_done,
    output logic                          o_found,
    output logic [IDX_W-1:0]              o_pick,
    output lfrs_pkg::t_room_rec           o_pick_rec,
    output logic [IDX_W-1:0]              o_early,
    output lfrs_pkg::t_room_rec           o_early_rec
);

    logic                r_busy;
    logic [NUM_W-1:0]    r_addr;
    logic                r_rd_vld;
    logic                r_rd_last;
    logic [IDX_W-1:0]    r_rd_idx;
    logic                r_found;
    logic [IDX_W-1:0]    r_pick;
    lfrs_pkg::t_room_rec r_pick_rec;
    logic [IDX_W-1:0]    r_early;
    lfrs_pkg::t_room_rec r_early_rec;
    logic                last_issue;
    logic                is_free;
    logic                is_earlier;

    assign last_issue = (r_addr == NUM_W'(i_n - 1'b1));
    assign o_rd_addr  = r_addr[IDX_W-1:0];

    // Address sequencer: one room read is issued per cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= 1'b0;
            r_addr    <= '0;
            r_rd_vld  <= 1'b0;
            r_rd_last <= 1'b0;
        end else begin
            r_rd_vld  <= r_busy;
            r_rd_last <= r_busy && last_issue;
            if (i_start) begin
                r_busy <= 1'b1;
                r_addr <= '0;
            end else if (r_busy) begin
                if (last_issue) begin
                    r_busy <= 1'b0;
                end else begin
                    r_addr <= r_addr + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_idx <= r_addr[IDX_W-1:0];
    end

    // Compare each returned entry against the request and the running minimum.
    assign is_free    = (i_rd_data.free_at <= lfrs_pkg::TIME_W'(i_start_time));
    assign is_earlier = (r_rd_idx == '0) || (i_rd_data.free_at < r_early_rec.free_at);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_found <= 1'b0;
        end else if (i_start) begin
            r_found <= 1'b0;
        end else if (r_rd_vld && !r_found && is_free) begin
            r_found <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_rd_vld) begin
            if (!r_found && is_free) begin
                r_pick     <= r_rd_idx;
                r_pick_rec <= i_rd_data;
            end
            if (is_earlier) begin
                r_early     <= r_rd_idx;
                r_early_rec <= i_rd_data;
            end
        end
    end

    assign o_done      = r_rd_vld && r_rd_last;
    assign o_found     = r_found;
    assign o_pick      = r_pick;
    assign o_pick_rec  = r_pick_rec;
    assign o_early     = r_early;
    assign o_early_rec = r_early_rec;

endmodule

// ----- rtl/core/lowest_free_room_scheduler_top.sv -----
// A booking's result follows its input transfer after a scan of the N active rooms, a
// calculation state and the output register; a new booking is taken only once the sequencer
// is back in idle after the result has been committed, which an output stall can hold off.
// The scan reads one room entry per cycle from the single-read-port room table.
// Reset (synchronous, active low) empties the pipeline, zeroes all room entries through
// per-entry valid bits, clears the busiest-room tracker and sets the room count to 16.
module lowest_free_room_scheduler_top #(
    parameter int ROOMS = lfrs_pkg::ROOMS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [lfrs_pkg::CFG_W-1:0]    i_cfg_data,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [lfrs_pkg::STAMP_W-1:0]  i_start_time,
    input  logic [lfrs_pkg::STAMP_W-1:0]  i_end_time,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [lfrs_pkg::ROOM_W-1:0]   o_room,
    output logic                          o_was_delayed,
    output logic [lfrs_pkg::TIME_W-1:0]   o_actual_begin,
    output logic [lfrs_pkg::TIME_W-1:0]   o_actual_finish,
    output logic [lfrs_pkg::ROOM_W-1:0]   o_busiest_room,
    output logic [lfrs_pkg::COUNT_W-1:0]  o_busiest_count
);

    localparam int IDX_W = (ROOMS > 1) ? $clog2(ROOMS) : 1;
    localparam int NUM_W = $clog2(ROOMS + 1);

    lfrs_pkg::t_state r_state;
    lfrs_pkg::t_state n_state;

    logic [lfrs_pkg::CFG_W-1:0]   r_cfg;
    logic [NUM_W-1:0]             r_n;
    logic [NUM_W-1:0]             n_active;
    logic [lfrs_pkg::STAMP_W-1:0] r_start_time;
    logic [lfrs_pkg::STAMP_W-1:0] r_end_time;

    logic [IDX_W-1:0]             r_pick;
    logic                         r_delayed;
    logic [lfrs_pkg::TIME_W-1:0]  r_begin;
    logic [lfrs_pkg::TIME_W-1:0]  r_finish;
    logic [lfrs_pkg::COUNT_W-1:0] r_new_cnt;
    logic [IDX_W-1:0]             r_busiest;
    logic [lfrs_pkg::COUNT_W-1:0] r_best_cnt;
    logic                         r_o_valid;

    logic                         accept;
    logic                         commit;
    logic                         scan_start;

    logic [IDX_W-1:0]             rd_addr;
    lfrs_pkg::t_room_rec          rd_data;
    lfrs_pkg::t_room_rec          wr_data;
    logic                         scan_done;
    logic                         found;
    logic [IDX_W-1:0]             pick;
    lfrs_pkg::t_room_rec          pick_rec;
    logic [IDX_W-1:0]             early;
    lfrs_pkg::t_room_rec          early_rec;

    logic [lfrs_pkg::STAMP_W-1:0] dur;
    logic [lfrs_pkg::TIME_W-1:0]  begin_sel;
    logic [lfrs_pkg::TIME_W:0]    fin_sum;
    logic [lfrs_pkg::COUNT_W-1:0] old_cnt;
    logic                         take_busiest;

    // Active room count: zero means one room, values above ROOMS clamp to ROOMS.
    always_comb begin
        if (r_cfg == '0) begin
            n_active = NUM_W'(1);
        end else if (32'(r_cfg) > 32'(ROOMS)) begin
            n_active = NUM_W'(ROOMS);
        end else begin
            n_active = NUM_W'(r_cfg);
        end
    end

    // Configuration register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= lfrs_pkg::CFG_RESET;
        end else if (i_cfg_we) begin
            r_cfg <= i_cfg_data;
        end
    end

    // Handshake decode.
    assign o_stall    = (r_state != lfrs_pkg::ST_IDLE);
    assign accept     = i_valid && !o_stall;
    assign scan_start = accept;
    assign commit     = (r_state == lfrs_pkg::ST_DONE) && (!r_o_valid || !i_stall);

    // Sequencer next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            lfrs_pkg::ST_IDLE: begin
                if (accept) n_state = lfrs_pkg::ST_SCAN;
            end
            lfrs_pkg::ST_SCAN: begin
                if (scan_done) n_state = lfrs_pkg::ST_CALC;
            end
            lfrs_pkg::ST_CALC: begin
                n_state = lfrs_pkg::ST_DONE;
            end
            lfrs_pkg::ST_DONE: begin
                if (commit) n_state = lfrs_pkg::ST_IDLE;
            end
            default: begin
                n_state = lfrs_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lfrs_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Capture the booking on its input transfer.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_start_time <= i_start_time;
            r_end_time   <= i_end_time;
            r_n          <= n_active;
        end
    end

    // Room table and the scanner that walks it.
    lfrs_room_mem #(
        .ROOMS(ROOMS)
    ) u_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data),
        .i_wr_en   (commit),
        .i_wr_addr (r_pick),
        .i_wr_data (wr_data)
    );

    lfrs_scan #(
        .ROOMS(ROOMS)
    ) u_scan (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (scan_start),
        .i_n          (r_n),
        .i_start_time (r_start_time),
        .o_rd_addr    (rd_addr),
        .i_rd_data    (rd_data),
        .o_done       (scan_done),
        .o_found      (found),
        .o_pick       (pick),
        .o_pick_rec   (pick_rec),
        .o_early      (early),
        .o_early_rec  (early_rec)
    );

    // Begin and finish times, with the duration clipped at zero and the sum saturated.
    assign dur       = (r_end_time > r_start_time) ? (r_end_time - r_start_time) : '0;
    assign begin_sel = found ? lfrs_pkg::TIME_W'(r_start_time) : early_rec.free_at;
    assign fin_sum   = {1'b0, begin_sel} + (lfrs_pkg::TIME_W + 1)'(dur);
    assign old_cnt   = found ? pick_rec.use_count : early_rec.use_count;

    always_ff @(posedge i_clk) begin
        if (r_state == lfrs_pkg::ST_CALC) begin
            r_pick    <= found ? pick : early;
            r_delayed <= !found;
            r_begin   <= begin_sel;
            r_finish  <= fin_sum[lfrs_pkg::TIME_W] ? lfrs_pkg::TIME_MAX
                                                    : fin_sum[lfrs_pkg::TIME_W-1:0];
            r_new_cnt <= (old_cnt == lfrs_pkg::COUNT_MAX) ? old_cnt : old_cnt + 1'b1;
        end
    end

    assign wr_data.free_at   = r_finish;
    assign wr_data.use_count = r_new_cnt;

    // Busiest room follows each update; lower index wins a tie.
    assign take_busiest = (r_new_cnt > r_best_cnt) ||
                          ((r_new_cnt == r_best_cnt) && (r_pick < r_busiest));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busiest  <= '0;
            r_best_cnt <= '0;
        end else if (commit) begin
            if (take_busiest || (r_pick == r_busiest)) begin
                r_busiest  <= r_pick;
                r_best_cnt <= r_new_cnt;
            end
        end
    end

    // Output register: a finished result waits here until its transfer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (commit) begin
            r_o_valid <= 1'b1;
        end else if (!i_stall) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (commit) begin
            o_room          <= lfrs_pkg::ROOM_W'(r_pick);
            o_was_delayed   <= r_delayed;
            o_actual_begin  <= r_begin;
            o_actual_finish <= r_finish;
            if (take_busiest || (r_pick == r_busiest)) begin
                o_busiest_room  <= lfrs_pkg::ROOM_W'(r_pick);
                o_busiest_count <= r_new_cnt;
            end else begin
                o_busiest_room  <= lfrs_pkg::ROOM_W'(r_busiest);
                o_busiest_count <= r_best_cnt;
            end
        end
    end

    assign o_valid = r_o_valid;

endmodule

// ----- tb/lowest_free_room_scheduler_top_tb.sv -----
module lowest_free_room_scheduler_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LONG_HOLD     = 150;
    localparam int STALL_LIMIT   = 2000;
    localparam int SETTLE_CYCLES = 4;
    localparam int END_CYCLES    = 30;
    localparam int PHASE_COUNT   = 12;
    localparam int PHASE_ITEMS   = 125;
    localparam int PRESSURE_PHASE = 4;
    localparam int LONG_STACK    = 24;
    localparam logic [lfrs_pkg::CFG_W-1:0] PHASE_ROOMS [PHASE_COUNT] =
        '{5'd16, 5'd3, 5'd1, 5'd31, 5'd8, 5'd0, 5'd17, 5'd2, 5'd12, 5'd5, 5'd4, 5'd16};

    // One booking outcome as it leaves the block.
    typedef struct packed {
        logic [lfrs_pkg::ROOM_W-1:0]  room;
        logic                         delayed;
        logic [lfrs_pkg::TIME_W-1:0]  begin_at;
        logic [lfrs_pkg::TIME_W-1:0]  finish_at;
        logic [lfrs_pkg::ROOM_W-1:0]  busiest_room;
        logic [lfrs_pkg::COUNT_W-1:0] busiest_count;
    } t_booking_result;

    // Room table shadow and the queue of outcomes still owed by the block.
    class booking_scoreboard;
        logic [lfrs_pkg::TIME_W-1:0]  free_at   [lfrs_pkg::ROOMS_DEF];
        logic [lfrs_pkg::COUNT_W-1:0] use_count [lfrs_pkg::ROOMS_DEF];
        logic [lfrs_pkg::ROOM_W-1:0]  busiest;
        logic [lfrs_pkg::CFG_W-1:0]   rooms_cfg;
        t_booking_result              expected_q[$];
        int                           error_count;

        function new();
            foreach (free_at[i]) begin
                free_at[i]   = '0;
                use_count[i] = '0;
            end
            busiest     = '0;
            rooms_cfg   = lfrs_pkg::CFG_RESET;
            error_count = 0;
        endfunction

        // Assign the booking to a room and record the outcome the block must report.
        function void note_booking(logic [lfrs_pkg::STAMP_W-1:0] req_start,
                                   logic [lfrs_pkg::STAMP_W-1:0] req_end);
            t_booking_result              r;
            int                           active;
            int                           pick;
            int                           early;
            bit                           found;
            logic [lfrs_pkg::STAMP_W-1:0] dur;
            logic [lfrs_pkg::TIME_W:0]    sum;

            active = (rooms_cfg == 0) ? 1 :
                     (rooms_cfg > lfrs_pkg::ROOMS_DEF) ? lfrs_pkg::ROOMS_DEF : int'(rooms_cfg);
            pick   = 0;
            early  = 0;
            found  = 1'b0;
            for (int i = 0; i < active; i++) begin
                if (!found && free_at[i] <= lfrs_pkg::TIME_W'(req_start)) begin
                    pick  = i;
                    found = 1'b1;
                end
                if (free_at[i] < free_at[early]) begin
                    early = i;
                end
            end
            if (!found) begin
                pick = early;
            end

            // A booking whose end is not after its start occupies no time.
            dur        = (req_end > req_start) ? req_end - req_start : '0;
            r.begin_at = found ? lfrs_pkg::TIME_W'(req_start) : free_at[pick];
            sum        = {1'b0, r.begin_at} + (lfrs_pkg::TIME_W + 1)'(dur);
            r.finish_at = sum[lfrs_pkg::TIME_W] ? lfrs_pkg::TIME_MAX
                                                : sum[lfrs_pkg::TIME_W-1:0];
            free_at[pick] = r.finish_at;
            if (use_count[pick] != lfrs_pkg::COUNT_MAX) begin
                use_count[pick] = use_count[pick] + 1'b1;
            end

            // The busiest room only moves when the room just used overtakes it or ties it at a lower index.
            if (use_count[pick] > use_count[busiest] ||
                (use_count[pick] == use_count[busiest] && pick < int'(busiest))) begin
                busiest = lfrs_pkg::ROOM_W'(pick);
            end

            r.room          = lfrs_pkg::ROOM_W'(pick);
            r.delayed       = !found;
            r.busiest_room  = busiest;
            r.busiest_count = use_count[busiest];
            expected_q.push_back(r);
        endfunction

        // Compare one result transfer against the oldest outstanding booking.
        function void check_result(t_booking_result got);
            t_booking_result want;

            if (expected_q.size() == 0) begin
                error_count++;
                if (error_count <= 10) begin
                    $display("result transfer with no booking outstanding: room %0d begin %0d",
                             got.room, got.begin_at);
                end
                return;
            end
            want = expected_q.pop_front();
            if (got.room !== want.room || got.delayed !== want.delayed ||
                got.begin_at !== want.begin_at || got.finish_at !== want.finish_at ||
                got.busiest_room !== want.busiest_room ||
                got.busiest_count !== want.busiest_count) begin
                error_count++;
                if (error_count <= 10) begin
                    $display({"booking mismatch: expected room %0d delayed %0b begin %0d ",
                              "finish %0d busiest %0d count %0d"},
                             want.room, want.delayed, want.begin_at, want.finish_at,
                             want.busiest_room, want.busiest_count);
                    $display({"                  got room %0d delayed %0b begin %0d ",
                              "finish %0d busiest %0d count %0d"},
                             got.room, got.delayed, got.begin_at, got.finish_at,
                             got.busiest_room, got.busiest_count);
                end
            end
        endfunction
    endclass

    logic                           i_clk;
    logic                           i_rst_n;
    logic                           i_cfg_we;
    logic [lfrs_pkg::CFG_W-1:0]     i_cfg_data;
    logic                           i_valid;
    logic                           o_stall;
    logic [lfrs_pkg::STAMP_W-1:0]   i_start_time;
    logic [lfrs_pkg::STAMP_W-1:0]   i_end_time;
    logic                           o_valid;
    logic                           i_stall;
    logic [lfrs_pkg::ROOM_W-1:0]    o_room;
    logic                           o_was_delayed;
    logic [lfrs_pkg::TIME_W-1:0]    o_actual_begin;
    logic [lfrs_pkg::TIME_W-1:0]    o_actual_finish;
    logic [lfrs_pkg::ROOM_W-1:0]    o_busiest_room;
    logic [lfrs_pkg::COUNT_W-1:0]   o_busiest_count;

    booking_scoreboard sb;
    bit                tx_idle_on;
    bit                rx_idle_on;
    bit                long_hold_req;

    lowest_free_room_scheduler_top #(
        .ROOMS(lfrs_pkg::ROOMS_DEF)
    ) u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_data     (i_cfg_data),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_start_time   (i_start_time),
        .i_end_time     (i_end_time),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_room         (o_room),
        .o_was_delayed  (o_was_delayed),
        .o_actual_begin (o_actual_begin),
        .o_actual_finish(o_actual_finish),
        .o_busiest_room (o_busiest_room),
        .o_busiest_count(o_busiest_count)
    );

    // Clock generation.
    initial begin : clock_gen
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Offer one booking and hold it until the block takes the transfer.
    // Called and returning at a falling edge.
    task automatic offer_booking(input logic [lfrs_pkg::STAMP_W-1:0] req_start,
                                 input logic [lfrs_pkg::STAMP_W-1:0] req_end);
        int gap;

        gap = tx_idle_on ? $urandom_range(0, 6) : 0;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid      <= 1'b1;
        i_start_time <= req_start;
        i_end_time   <= req_end;
        do @(posedge i_clk); while (o_stall);
        sb.note_booking(req_start, req_end);
        @(negedge i_clk);
    endtask

    // Change the number of rooms in use once every booking has come back.
    task automatic set_rooms(input logic [lfrs_pkg::CFG_W-1:0] value);
        i_valid <= 1'b0;
        while (sb.expected_q.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= value;
        @(negedge i_clk);
        i_cfg_we     <= 1'b0;
        sb.rooms_cfg = value;
    endtask

    // Result side: random hold-offs, one long one on request, and a check per transfer.
    initial begin : result_sink
        int              hold;
        t_booking_result got;

        i_stall = 1'b0;
        wait (i_rst_n === 1'b1);
        @(negedge i_clk);
        forever begin
            hold = rx_idle_on ? $urandom_range(0, 6) : 0;
            if (long_hold_req) begin
                hold          = LONG_HOLD;
                long_hold_req = 1'b0;
            end
            if (hold > 0) begin
                i_stall <= 1'b1;
                repeat (hold) @(negedge i_clk);
            end
            i_stall <= 1'b0;
            do @(posedge i_clk); while (!o_valid);
            got.room          = o_room;
            got.delayed       = o_was_delayed;
            got.begin_at      = o_actual_begin;
            got.finish_at     = o_actual_finish;
            got.busiest_room  = o_busiest_room;
            got.busiest_count = o_busiest_count;
            sb.check_result(got);
            @(negedge i_clk);
        end
    end

    // Watchdog: give up when no transfer happens on either side for too long.
    initial begin : watchdog
        int quiet;

        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("lowest_free_room_scheduler_top verification failed");
        $finish;
    end

    // Main stimulus sequence.
    initial begin : stimulus
        logic [lfrs_pkg::STAMP_W-1:0] cursor;
        logic [lfrs_pkg::STAMP_W-1:0] req_start;
        logic [lfrs_pkg::STAMP_W-1:0] req_end;
        logic [lfrs_pkg::CFG_W-1:0]   rooms;
        int                           inc_max;
        int                           dur_max;
        int                           kind;

        sb            = new();
        i_rst_n       = 1'b0;
        i_valid       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_data    = '0;
        i_start_time  = '0;
        i_end_time    = '0;
        tx_idle_on    = 1'b1;
        rx_idle_on    = 1'b1;
        long_hold_req = 1'b0;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: zero and reversed durations with all sixteen rooms after reset.
        offer_booking(32'd0, 32'd0);
        offer_booking(32'd0, 32'd10);
        offer_booking(32'd0, 32'd10);
        offer_booking(32'd3, 32'd1);
        offer_booking(32'd5, 32'd5);

        // A single room forces postponement, also with a zero duration.
        set_rooms(5'd1);
        offer_booking(32'd20, 32'd30);
        offer_booking(32'd21, 32'd25);
        offer_booking(32'd22, 32'd22);

        // A room count of zero behaves as one room.
        set_rooms(5'd0);
        offer_booking(32'd40, 32'd50);
        offer_booking(32'd41, 32'd45);

        // Two rooms freeing at the same time: the lower index takes the postponed booking.
        set_rooms(5'd2);
        offer_booking(32'd100, 32'd110);
        offer_booking(32'd100, 32'd110);
        offer_booking(32'd101, 32'd105);

        // Counts above the number of rooms are clipped.
        set_rooms(5'd31);
        offer_booking(32'd500, 32'd600);
        offer_booking(32'd500, 32'd600);
        offer_booking(32'd500, 32'd600);
        set_rooms(5'd17);
        offer_booking(32'd700, 32'd800);
        offer_booking(32'd450, 32'd460);

        // Random phases: ascending bookings with random density, some noise.
        for (int phase = 0; phase < PHASE_COUNT; phase++) begin
            rooms = (phase >= PHASE_COUNT - 2) ? lfrs_pkg::CFG_W'($urandom_range(0, 31))
                                               : PHASE_ROOMS[phase];
            set_rooms(rooms);
            tx_idle_on = ($urandom_range(0, 3) != 0);
            rx_idle_on = ($urandom_range(0, 3) != 0);
            if (phase == PRESSURE_PHASE) begin
                tx_idle_on    = 1'b0;
                long_hold_req = 1'b1;
            end
            inc_max = $urandom_range(1, 30);
            dur_max = $urandom_range(1, 600);
            cursor  = lfrs_pkg::STAMP_W'(phase) * 32'h1500_0000 +
                      $urandom_range(32'h0FFF_FFFF, 0);

            // Sometimes one long booking ties up the lowest free room for the whole phase,
            // which lets another room become the busiest.
            if ($urandom_range(0, 1) == 0) begin
                offer_booking(cursor, cursor + $urandom_range(200000, 20000));
            end

            for (int n = 0; n < PHASE_ITEMS; n++) begin
                kind = $urandom_range(0, 99);
                if (kind < 90) begin
                    cursor    = cursor + $urandom_range(inc_max, 0);
                    req_start = cursor;
                    req_end   = cursor + $urandom_range(dur_max, 1);
                end else if (kind < 95) begin
                    cursor    = cursor + $urandom_range(inc_max, 0);
                    req_start = cursor;
                    req_end   = cursor - $urandom_range(3, 0);
                end else begin
                    req_start = $urandom;
                    req_end   = $urandom;
                end
                offer_booking(req_start, req_end);
            end
        end

        // Top of the time range.
        set_rooms(5'd16);
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
        offer_booking(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        offer_booking(32'hFFFF_FFFF, 32'h0000_0000);
        offer_booking(32'h0000_0000, 32'hFFFF_FFFF);
        offer_booking(32'h8000_0000, 32'h7FFF_FFFF);

        // Stack maximum-length bookings onto one room so that each later one is postponed
        // far beyond the 32-bit range of the requests.
        set_rooms(5'd1);
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        for (int n = 0; n < LONG_STACK; n++) begin
            offer_booking(32'h0000_0000, 32'hFFFF_FFFF);
        end
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
        offer_booking(32'h0000_0000, 32'hFFFF_FFFF);
        offer_booking(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        set_rooms(5'd2);
        offer_booking(32'd5, 32'd9);
        offer_booking(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        offer_booking(32'd7, 32'd3);

        // Drain and let the block settle before the verdict.
        i_valid <= 1'b0;
        while (sb.expected_q.size() != 0) @(negedge i_clk);
        repeat (END_CYCLES) @(negedge i_clk);
        if (sb.error_count == 0 && sb.expected_q.size() == 0) begin
            $display("lowest_free_room_scheduler_top verification clean");
        end else begin
            $display("lowest_free_room_scheduler_top verification failed");
        end
        $finish;
    end

endmodule
